### rtl/core/tce_pkg.sv
// ----------------------------------------------------------------------------
// tce_pkg
// Shared widths, opcodes and helpers for the tiny CPU execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tce_pkg;

    localparam int unsigned WORD_W   = 16;
    localparam int unsigned NUM_REGS = 8;
    localparam int unsigned REG_IDX_W = 3;
    localparam int unsigned IMM_W    = 6;
    localparam int unsigned OP_W     = 4;

    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    typedef logic [OP_W-1:0]      opcode_t;

    // Instruction opcodes
    localparam opcode_t OP_HALT = 4'h0;
    localparam opcode_t OP_ADD  = 4'h1;
    localparam opcode_t OP_AND  = 4'h2;
    localparam opcode_t OP_NOT  = 4'h3;
    localparam opcode_t OP_JZ   = 4'h4;
    localparam opcode_t OP_JMP  = 4'h5;
    localparam opcode_t OP_LDI  = 4'h6;
    localparam opcode_t OP_MUL  = 4'h7;
    localparam opcode_t OP_SUBI = 4'h8;

    // Condition flags after a register write
    typedef struct packed {
        logic zero;
        logic negative;
        logic positive;
    } flags_t;

    localparam flags_t FLAGS_RESET = '{zero: 1'b1, negative: 1'b0, positive: 1'b0};

    // Derive the one-hot flag set from a written value
    function automatic flags_t flags_of(input word_t v);
        flags_t f;
        f.zero     = (v == '0);
        f.negative = !f.zero && v[WORD_W-1];
        f.positive = !f.zero && !v[WORD_W-1];
        return f;
    endfunction

endpackage

`default_nettype wire

### rtl/core/tiny_cpu_execute_unit_top.sv
// ----------------------------------------------------------------------------
// tiny_cpu_execute_unit_top
// An accepted instruction beat is held in the input stage, then executed into the registered result stage.
// Throughput: one instruction per cycle; the register file RAM is read at
// accept, the execute stage (adder, one 16x16 multiplier) retires unless stalled.
// Reset: registers read as zero, PC zero, zero flag set, not halted; no
// clearing pass, the block accepts beats right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tiny_cpu_execute_unit_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        instr_valid,
    output logic             instr_ready,
    input  wire logic [15:0] instr_word,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic      [15:0] instr_pc,
    output logic      [15:0] next_pc,
    output logic             halted,
    output logic             reg_written,
    output logic      [2:0]  reg_index,
    output logic      [15:0] reg_value,
    output logic             flag_zero,
    output logic             flag_negative,
    output logic             flag_positive
);

    // ------------------------------------------------------------------
    // Handshake control
    // ------------------------------------------------------------------
    logic in_fire;
    logic exec_fire;
    logic ivalid_reg;
    logic ovalid_reg;

    assign exec_fire   = ivalid_reg && (!ovalid_reg || result_ready);
    assign instr_ready = !ivalid_reg || exec_fire;
    assign in_fire     = instr_valid && instr_ready;

    // ------------------------------------------------------------------
    // Architectural state
    // ------------------------------------------------------------------
    tce_pkg::word_t                   pc_reg;
    tce_pkg::flags_t                  flags_reg;
    logic                             halt_reg;
    logic [tce_pkg::NUM_REGS-1:0]     rvld_reg;

    // Write port of the execute stage
    logic              wr_en;
    tce_pkg::reg_idx_t wr_idx;
    tce_pkg::word_t    wr_val;

    // ------------------------------------------------------------------
    // Input stage: instruction and operand bypass info captured at accept
    // ------------------------------------------------------------------
    tce_pkg::word_t    instr_reg;
    logic              a_byp_reg;
    logic              b_byp_reg;
    logic              a_vld_reg;
    logic              b_vld_reg;
    tce_pkg::word_t    byp_val_reg;

    tce_pkg::reg_idx_t rd_in;
    tce_pkg::reg_idx_t rs_in;

    assign rd_in = instr_word[11:9];
    assign rs_in = instr_word[8:6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivalid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            ivalid_reg <= 1'b1;
        end
        else if (exec_fire)
        begin
            ivalid_reg <= 1'b0;
        end
    end

    // Hold the beat; forward the write that lands on the same edge
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            instr_reg   <= instr_word;
            a_byp_reg   <= wr_en && (wr_idx == rd_in);
            b_byp_reg   <= wr_en && (wr_idx == rs_in);
            a_vld_reg   <= rvld_reg[rd_in];
            b_vld_reg   <= rvld_reg[rs_in];
            byp_val_reg <= wr_val;
        end
    end

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    tce_pkg::word_t ram_a;
    tce_pkg::word_t ram_b;

    tce_ram #(
        .WIDTH (tce_pkg::WORD_W),
        .DEPTH (tce_pkg::NUM_REGS)
    ) u_regfile (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_idx),
        .wr_data   (wr_val),
        .rd_en     (in_fire),
        .rd_addr_a (rd_in),
        .rd_addr_b (rs_in),
        .rd_data_a (ram_a),
        .rd_data_b (ram_b)
    );

    // Track which entries were ever written; others read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvld_reg <= '0;
        end
        else if (wr_en)
        begin
            rvld_reg[wr_idx] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Execute
    // ------------------------------------------------------------------
    tce_pkg::opcode_t op;
    tce_pkg::word_t   opa;
    tce_pkg::word_t   opb;
    tce_pkg::word_t   imm;
    tce_pkg::word_t   pc1;
    logic [2*tce_pkg::WORD_W-1:0] prod;

    tce_pkg::word_t   pc_next;
    logic             halt_next;
    logic             wrote;
    tce_pkg::word_t   res;
    tce_pkg::flags_t  flags_next;

    assign op   = instr_reg[15:12];
    assign imm  = {{(tce_pkg::WORD_W-tce_pkg::IMM_W){1'b0}}, instr_reg[tce_pkg::IMM_W-1:0]};
    assign opa  = a_byp_reg ? byp_val_reg : (a_vld_reg ? ram_a : '0);
    assign opb  = b_byp_reg ? byp_val_reg : (b_vld_reg ? ram_b : '0);
    assign pc1  = pc_reg + 16'd1;
    assign prod = opa * opb;

    // Decode and compute one instruction
    always_comb
    begin
        pc_next   = pc_reg;
        halt_next = halt_reg;
        wrote     = 1'b0;
        res       = '0;
        if (!halt_reg)
        begin
            pc_next = pc1;
            unique case (op)
                tce_pkg::OP_HALT: halt_next = 1'b1;
                tce_pkg::OP_ADD:
                begin
                    res   = opa + opb;
                    wrote = 1'b1;
                end
                tce_pkg::OP_AND:
                begin
                    res   = opa & opb;
                    wrote = 1'b1;
                end
                tce_pkg::OP_NOT:
                begin
                    res   = ~opb;
                    wrote = 1'b1;
                end
                tce_pkg::OP_JZ:
                begin
                    if (opa == '0)
                    begin
                        pc_next = pc1 + imm;
                    end
                end
                tce_pkg::OP_JMP: pc_next = opa;
                tce_pkg::OP_LDI:
                begin
                    res   = imm;
                    wrote = 1'b1;
                end
                tce_pkg::OP_MUL:
                begin
                    res   = prod[tce_pkg::WORD_W-1:0];
                    wrote = 1'b1;
                end
                tce_pkg::OP_SUBI:
                begin
                    res   = opa - imm;
                    wrote = 1'b1;
                end
                default: pc_next = pc1;
            endcase
        end
        flags_next = wrote ? tce_pkg::flags_of(res) : flags_reg;
    end

    assign wr_en  = exec_fire && wrote;
    assign wr_idx = instr_reg[11:9];
    assign wr_val = res;

    // Advance architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= '0;
            flags_reg <= tce_pkg::FLAGS_RESET;
            halt_reg  <= 1'b0;
        end
        else if (exec_fire)
        begin
            pc_reg    <= pc_next;
            flags_reg <= flags_next;
            halt_reg  <= halt_next;
        end
    end

    // ------------------------------------------------------------------
    // Result stage
    // ------------------------------------------------------------------
    tce_pkg::word_t    instr_pc_reg;
    tce_pkg::word_t    next_pc_reg;
    logic              halted_reg;
    logic              reg_written_reg;
    tce_pkg::reg_idx_t reg_index_reg;
    tce_pkg::word_t    reg_value_reg;
    tce_pkg::flags_t   oflags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (exec_fire)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    // Load the result beat
    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            instr_pc_reg    <= pc_reg;
            next_pc_reg     <= pc_next;
            halted_reg      <= halt_next;
            reg_written_reg <= wrote;
            reg_index_reg   <= wrote ? wr_idx : '0;
            reg_value_reg   <= wrote ? res : '0;
            oflags_reg      <= flags_next;
        end
    end

    assign result_valid  = ovalid_reg;
    assign instr_pc      = instr_pc_reg;
    assign next_pc       = next_pc_reg;
    assign halted        = halted_reg;
    assign reg_written   = reg_written_reg;
    assign reg_index     = reg_index_reg;
    assign reg_value     = reg_value_reg;
    assign flag_zero     = oflags_reg.zero;
    assign flag_negative = oflags_reg.negative;
    assign flag_positive = oflags_reg.positive;

endmodule

`default_nettype wire

### rtl/core/tce_ram.sv
// ----------------------------------------------------------------------------
// tce_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tce_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_a,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write one entry; read two entries, old data on a same-address collision
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a <= mem_reg[rd_addr_a];
            rd_data_b <= mem_reg[rd_addr_b];
        end
    end

endmodule

`default_nettype wire
